// File: sv/peer_liveness_table_assert.svh
// Assertion macros used by the checker module of the peer liveness table.
`ifndef PEER_LIVENESS_TABLE_ASSERT_SVH
`define PEER_LIVENESS_TABLE_ASSERT_SVH

// Concurrent assertion on clk, switched off while arst_n is low.
`define PLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define PLT_IMPLY(lbl, ante, cons, msg) \
	`PLT_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PLT_NEXT(lbl, ante, cons, msg) \
	`PLT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/plt_pkg.sv
// Package with the types, widths and codes of the peer liveness table.
`timescale 1ns / 1ps

package plt_pkg;

	localparam int MAX_PEERS = 8;
	localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam int CNT_W     = $clog2(MAX_PEERS + 1);

	localparam int ADDR_W     = 48;
	localparam int TIME_W     = 32;
	localparam int TMO_W      = 16;
	localparam int GRP_W      = 8;
	localparam int STATUS_W   = 3;
	localparam int SLOT_OUT_W = 3;
	localparam int NUM_OUT_W  = 4;
	localparam int MASK_W     = 8;
	localparam int MASK_N     = (MAX_PEERS < MASK_W) ? MAX_PEERS : MASK_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(3000);

	typedef enum logic [STATUS_W-1:0] {
		ST_REFRESHED   = 3'd0,
		ST_ADDED       = 3'd1,
		ST_FULL        = 3'd2,
		ST_NOT_LEADER  = 3'd3,
		ST_BAD_FRAME   = 3'd4,
		ST_WRONG_GROUP = 3'd5,
		ST_SWEEP_DONE  = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEADER  = 2'd0,
		REG_GROUP   = 2'd1,
		REG_TIMEOUT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_SWEEP  = 1'b1
	} op_t;

	// Read and write controls of the entry store.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_addr_en;
		logic             wr_time_en;
		logic [IDX_W-1:0] wr_idx;
	} mem_ctl_t;

endpackage

// File: sv/plt_if.sv
// Valid/ready channel interfaces for heartbeat/sweep items and their results.
`timescale 1ns / 1ps

interface plt_in_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [plt_pkg::ADDR_W-1:0] station_mac;
	logic [plt_pkg::GRP_W-1:0]  heartbeat_group;
	logic                       frame_ok;
	logic [plt_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, func, station_mac, heartbeat_group, frame_ok, now_ms,
		input ready);
	modport sink (input valid, func, station_mac, heartbeat_group, frame_ok, now_ms,
		output ready);
endinterface

interface plt_out_if;
	logic                           valid;
	logic                           ready;
	plt_pkg::status_t               status;
	logic [plt_pkg::SLOT_OUT_W-1:0] entry_index;
	logic [plt_pkg::NUM_OUT_W-1:0]  newly_offline;
	logic [plt_pkg::NUM_OUT_W-1:0]  online_count;
	logic [plt_pkg::MASK_W-1:0]     online_mask;
	logic [plt_pkg::NUM_OUT_W-1:0]  used_entries;

	modport source (output valid, status, entry_index, newly_offline, online_count,
		online_mask, used_entries, input ready);
	modport sink (input valid, status, entry_index, newly_offline, online_count,
		online_mask, used_entries, output ready);
endinterface

// File: sv/peer_liveness_table.sv
// Peer liveness table: a heartbeat refreshes or adds a peer entry, a sweep ages entries out.
// A rejected item (not leader, bad frame, wrong group) goes straight to the final state; a sweep
// walks the filled slots and then finishes, and a heartbeat lookup walks them and then updates
// the table before it finishes. The table has a single read port and one shared subtractor, so
// stored entries are compared one per cycle, each from a registered read. A hit stops the walk
// early. The input is not ready until the result has been loaded into the output register and
// is ready again the cycle after. A result that waits for the sink holds the block in its final
// state. The output register lets the next item in while the result waits.
// Configuration: cfg_index 0 leader mode, 1 group number, 2 offline timeout in ms (reset
// 3000); writes to other indexes are ignored.
`timescale 1ns / 1ps

module peer_liveness_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [plt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plt_pkg::CFG_DATA_W-1:0] cfg_data,
	plt_in_if.sink                         in_ch,
	plt_out_if.source                      out_ch
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_DONE
	} state_t;

	state_t                           state_q;
	logic                             leader_q;
	logic [plt_pkg::GRP_W-1:0]        group_q;
	logic [plt_pkg::TMO_W-1:0]        timeout_q;

	plt_pkg::op_t                     op_q;
	plt_pkg::status_t                 status_q;
	logic [plt_pkg::ADDR_W-1:0]       mac_q;
	logic [plt_pkg::TIME_W-1:0]       now_q;
	logic [plt_pkg::CNT_W-1:0]        issue_q;
	logic [plt_pkg::CNT_W-1:0]        fill_q;
	logic [plt_pkg::CNT_W-1:0]        online_cnt_q;
	logic [plt_pkg::CNT_W-1:0]        dropped_q;
	logic [plt_pkg::MAX_PEERS-1:0]    online_q;
	logic                             hit_q;
	logic [plt_pkg::IDX_W-1:0]        slot_q;
	logic                             pend_s1;
	logic [plt_pkg::IDX_W-1:0]        ridx_s1;

	logic                             out_valid_q;
	plt_pkg::status_t                 out_status_q;
	logic [plt_pkg::SLOT_OUT_W-1:0]   out_index_q;
	logic [plt_pkg::NUM_OUT_W-1:0]    out_dropped_q;
	logic [plt_pkg::NUM_OUT_W-1:0]    out_count_q;
	logic [plt_pkg::MASK_W-1:0]       out_mask_q;
	logic [plt_pkg::NUM_OUT_W-1:0]    out_used_q;

	plt_pkg::mem_ctl_t                mem_ctl;
	logic [plt_pkg::ADDR_W-1:0]       rd_mac;
	logic [plt_pkg::TIME_W-1:0]       rd_time;
	logic                             cmp_hit;
	logic                             issue;
	logic                             in_acc;
	logic                             room;
	logic                             out_load;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign issue    = (state_q == S_SCAN) && (issue_q < fill_q);
	assign room     = fill_q < plt_pkg::CNT_W'(plt_pkg::MAX_PEERS);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.entry_index   = out_index_q;
	assign out_ch.newly_offline = out_dropped_q;
	assign out_ch.online_count  = out_count_q;
	assign out_ch.online_mask   = out_mask_q;
	assign out_ch.used_entries  = out_used_q;

	always_comb begin
		mem_ctl.rd_en      = issue;
		mem_ctl.rd_idx     = issue_q[plt_pkg::IDX_W-1:0];
		mem_ctl.wr_addr_en = (state_q == S_UPDATE) && !hit_q && room;
		mem_ctl.wr_time_en = (state_q == S_UPDATE) && (hit_q || room);
		mem_ctl.wr_idx     = hit_q ? slot_q : fill_q[plt_pkg::IDX_W-1:0];
	end

	plt_mem u_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.wr_mac   (mac_q),
		.wr_time  (now_q),
		.rd_mac_q (rd_mac),
		.rd_time_q(rd_time)
	);

	plt_cmp u_cmp (
		.op      (op_q),
		.key_mac (mac_q),
		.now_ms  (now_q),
		.ent_mac (rd_mac),
		.ent_time(rd_time),
		.timeout (timeout_q),
		.hit     (cmp_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			leader_q      <= 1'b0;
			group_q       <= '0;
			timeout_q     <= plt_pkg::TIMEOUT_RST;
			op_q          <= plt_pkg::OP_LOOKUP;
			status_q      <= plt_pkg::ST_NOT_LEADER;
			mac_q         <= '0;
			now_q         <= '0;
			issue_q       <= '0;
			fill_q        <= '0;
			online_cnt_q  <= '0;
			dropped_q     <= '0;
			online_q      <= '0;
			hit_q         <= 1'b0;
			slot_q        <= '0;
			pend_s1       <= 1'b0;
			ridx_s1       <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= plt_pkg::ST_NOT_LEADER;
			out_index_q   <= '0;
			out_dropped_q <= '0;
			out_count_q   <= '0;
			out_mask_q    <= '0;
			out_used_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (plt_pkg::cfg_reg_t'(cfg_index))
					plt_pkg::REG_LEADER:  leader_q  <= cfg_data[0];
					plt_pkg::REG_GROUP:   group_q   <= cfg_data[plt_pkg::GRP_W-1:0];
					plt_pkg::REG_TIMEOUT: timeout_q <= cfg_data[plt_pkg::TMO_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			// The read pipeline only runs while scanning.
			pend_s1 <= issue;
			ridx_s1 <= issue_q[plt_pkg::IDX_W-1:0];

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mac_q     <= in_ch.station_mac;
						now_q     <= in_ch.now_ms;
						issue_q   <= '0;
						dropped_q <= '0;
						hit_q     <= 1'b0;
						slot_q    <= '0;
						if (!leader_q) begin
							status_q <= plt_pkg::ST_NOT_LEADER;
							state_q  <= S_DONE;
						end else if (in_ch.func) begin
							op_q    <= plt_pkg::OP_SWEEP;
							state_q <= S_SCAN;
						end else if (!in_ch.frame_ok) begin
							status_q <= plt_pkg::ST_BAD_FRAME;
							state_q  <= S_DONE;
						end else if (in_ch.heartbeat_group != group_q) begin
							status_q <= plt_pkg::ST_WRONG_GROUP;
							state_q  <= S_DONE;
						end else begin
							op_q    <= plt_pkg::OP_LOOKUP;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (op_q == plt_pkg::OP_LOOKUP && pend_s1 && cmp_hit) begin
						// First matching slot wins; later reads in flight are dropped.
						hit_q   <= 1'b1;
						slot_q  <= ridx_s1;
						state_q <= S_UPDATE;
					end else begin
						if (op_q == plt_pkg::OP_SWEEP && pend_s1 && cmp_hit &&
							online_q[ridx_s1]) begin
							online_q[ridx_s1] <= 1'b0;
							online_cnt_q      <= online_cnt_q - 1'b1;
							dropped_q         <= dropped_q + 1'b1;
						end
						if (!issue && !pend_s1) begin
							if (op_q == plt_pkg::OP_SWEEP) begin
								status_q <= plt_pkg::ST_SWEEP_DONE;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_UPDATE;
							end
						end
					end
				end
				S_UPDATE: begin
					if (hit_q) begin
						status_q         <= plt_pkg::ST_REFRESHED;
						online_q[slot_q] <= 1'b1;
						if (!online_q[slot_q]) begin
							online_cnt_q <= online_cnt_q + 1'b1;
						end
					end else if (room) begin
						status_q                               <= plt_pkg::ST_ADDED;
						slot_q                                 <= fill_q[plt_pkg::IDX_W-1:0];
						online_q[fill_q[plt_pkg::IDX_W-1:0]]   <= 1'b1;
						online_cnt_q                           <= online_cnt_q + 1'b1;
						fill_q                                 <= fill_q + 1'b1;
					end else begin
						status_q <= plt_pkg::ST_FULL;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_status_q  <= status_q;
						out_index_q   <= (status_q == plt_pkg::ST_REFRESHED ||
							status_q == plt_pkg::ST_ADDED) ?
							plt_pkg::SLOT_OUT_W'(slot_q) : '0;
						out_dropped_q <= plt_pkg::NUM_OUT_W'(dropped_q);
						out_count_q   <= plt_pkg::NUM_OUT_W'(online_cnt_q);
						out_mask_q    <= plt_pkg::MASK_W'(online_q[plt_pkg::MASK_N-1:0]);
						out_used_q    <= plt_pkg::NUM_OUT_W'(fill_q);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/plt_mem.sv
// Entry store: peer addresses and last-seen times, one write and one registered read.
`timescale 1ns / 1ps

module plt_mem (
	input  logic                       clk,
	input  plt_pkg::mem_ctl_t          ctl,
	input  logic [plt_pkg::ADDR_W-1:0] wr_mac,
	input  logic [plt_pkg::TIME_W-1:0] wr_time,
	output logic [plt_pkg::ADDR_W-1:0] rd_mac_q,
	output logic [plt_pkg::TIME_W-1:0] rd_time_q
);

	logic [plt_pkg::ADDR_W-1:0] addr_mem [plt_pkg::MAX_PEERS];
	logic [plt_pkg::TIME_W-1:0] time_mem [plt_pkg::MAX_PEERS];

	always_ff @(posedge clk) begin
		if (ctl.wr_addr_en) begin
			addr_mem[ctl.wr_idx] <= wr_mac;
		end
		if (ctl.wr_time_en) begin
			time_mem[ctl.wr_idx] <= wr_time;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_mac_q  <= addr_mem[ctl.rd_idx];
			rd_time_q <= time_mem[ctl.rd_idx];
		end
	end

endmodule

// File: sv/plt_cmp.sv
// Shared compare unit: one subtractor serves both address match and age check.
`timescale 1ns / 1ps

module plt_cmp (
	input  plt_pkg::op_t               op,
	input  logic [plt_pkg::ADDR_W-1:0] key_mac,
	input  logic [plt_pkg::TIME_W-1:0] now_ms,
	input  logic [plt_pkg::ADDR_W-1:0] ent_mac,
	input  logic [plt_pkg::TIME_W-1:0] ent_time,
	input  logic [plt_pkg::TMO_W-1:0]  timeout,
	output logic                       hit
);

	logic [plt_pkg::ADDR_W-1:0] opa;
	logic [plt_pkg::ADDR_W-1:0] opb;
	logic [plt_pkg::ADDR_W-1:0] diff;

	always_comb begin
		if (op == plt_pkg::OP_SWEEP) begin
			opa = plt_pkg::ADDR_W'(now_ms);
			opb = plt_pkg::ADDR_W'(ent_time);
		end else begin
			opa = key_mac;
			opb = ent_mac;
		end
		diff = opa - opb;
		// The low word of the difference is the wrapped age.
		if (op == plt_pkg::OP_SWEEP) begin
			hit = diff[plt_pkg::TIME_W-1:0] > plt_pkg::TIME_W'(timeout);
		end else begin
			hit = (diff == '0);
		end
	end

endmodule

// File: sv/plt_checker.sv
// Port-level checker for the peer liveness table, bound to the top level.
`timescale 1ns / 1ps
`include "peer_liveness_table_assert.svh"

module plt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  plt_pkg::status_t               status,
	input  logic [plt_pkg::SLOT_OUT_W-1:0] entry_index,
	input  logic [plt_pkg::NUM_OUT_W-1:0]  newly_offline,
	input  logic [plt_pkg::NUM_OUT_W-1:0]  online_count,
	input  logic [plt_pkg::MASK_W-1:0]     online_mask
);

	// A stalled result keeps its status.
	`PLT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result changed while stalled")

	// One transaction at a time: the input closes right after an acceptance.
	`PLT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input ready right after acceptance")

	`PLT_IMPLY(a_index_zero, out_valid && status != plt_pkg::ST_REFRESHED && status != plt_pkg::ST_ADDED, entry_index == '0 && (status == plt_pkg::ST_SWEEP_DONE || newly_offline == '0), "index or drop count set for wrong status")

	`PLT_IMPLY(a_mask_count, out_valid, plt_pkg::MAX_PEERS > plt_pkg::MASK_W || $countones(online_mask) == online_count, "online mask and count disagree")

endmodule

bind peer_liveness_table plt_checker u_plt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.status       (out_ch.status),
	.entry_index  (out_ch.entry_index),
	.newly_offline(out_ch.newly_offline),
	.online_count (out_ch.online_count),
	.online_mask  (out_ch.online_mask)
);

// File: sim/tb_top.sv
// Self-checking testbench for the peer liveness table: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 300;
	localparam int REPORT_LIMIT  = 10;
	localparam int NO_EVENT      = -1;

	typedef struct packed {
		plt_pkg::status_t                status;
		logic [plt_pkg::SLOT_OUT_W-1:0]  entry_index;
		logic [plt_pkg::NUM_OUT_W-1:0]   newly_offline;
		logic [plt_pkg::NUM_OUT_W-1:0]   online_count;
		logic [plt_pkg::MASK_W-1:0]      online_mask;
		logic [plt_pkg::NUM_OUT_W-1:0]   used_entries;
	} peer_result_t;

	typedef struct packed {
		plt_pkg::op_t               func;
		logic [plt_pkg::ADDR_W-1:0] mac;
		logic [plt_pkg::GRP_W-1:0]  grp;
		logic                       frame_ok;
		logic [plt_pkg::TIME_W-1:0] now;
	} beat_t;

	typedef enum logic {
		ROW_BEAT,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		beat_t                     beat;
		bit                        typed;
		peer_result_t              result;
		logic                      leader;
		logic [plt_pkg::GRP_W-1:0] grp;
		logic [plt_pkg::TMO_W-1:0] tmo;
	} dir_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [plt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [plt_pkg::CFG_DATA_W-1:0] cfg_data;

	plt_in_if  in_ch();
	plt_out_if out_ch();

	peer_liveness_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the configuration and the peer table.
	logic                       shadow_leader;
	logic [plt_pkg::GRP_W-1:0]  shadow_group;
	logic [plt_pkg::TMO_W-1:0]  shadow_tmo;
	logic [plt_pkg::ADDR_W-1:0] peer_mac [plt_pkg::MAX_PEERS];
	logic [plt_pkg::TIME_W-1:0] peer_seen [plt_pkg::MAX_PEERS];
	logic                       peer_online [plt_pkg::MAX_PEERS];
	int                         peer_fill;

	peer_result_t pending_q [$];
	int           errors = 0;
	bit           no_idle;
	bit           long_hold_req;

	function automatic peer_result_t track_beat(beat_t b);
		peer_result_t r;
		logic [plt_pkg::TIME_W-1:0] age;
		int hit;
		int i;
		r = '0;
		hit = -1;
		if (!shadow_leader) begin
			r.status = plt_pkg::ST_NOT_LEADER;
		end else if (b.func == plt_pkg::OP_SWEEP) begin
			r.status = plt_pkg::ST_SWEEP_DONE;
			for (i = 0; i < peer_fill; i++) begin
				age = b.now - peer_seen[i];
				if (peer_online[i] && age > plt_pkg::TIME_W'(shadow_tmo)) begin
					peer_online[i] = 1'b0;
					r.newly_offline = r.newly_offline + 1'b1;
				end
			end
		end else if (!b.frame_ok) begin
			r.status = plt_pkg::ST_BAD_FRAME;
		end else if (b.grp != shadow_group) begin
			r.status = plt_pkg::ST_WRONG_GROUP;
		end else begin
			for (i = 0; i < peer_fill; i++)
				if (hit < 0 && peer_mac[i] == b.mac)
					hit = i;
			if (hit >= 0) begin
				peer_seen[hit] = b.now;
				peer_online[hit] = 1'b1;
				r.status = plt_pkg::ST_REFRESHED;
				r.entry_index = plt_pkg::SLOT_OUT_W'(hit);
			end else if (peer_fill < plt_pkg::MAX_PEERS) begin
				peer_mac[peer_fill] = b.mac;
				peer_seen[peer_fill] = b.now;
				peer_online[peer_fill] = 1'b1;
				r.status = plt_pkg::ST_ADDED;
				r.entry_index = plt_pkg::SLOT_OUT_W'(peer_fill);
				peer_fill++;
			end else begin
				r.status = plt_pkg::ST_FULL;
			end
		end
		for (i = 0; i < peer_fill; i++) begin
			if (peer_online[i]) begin
				r.online_count = r.online_count + 1'b1;
				if (i < plt_pkg::MASK_W)
					r.online_mask[i] = 1'b1;
			end
		end
		r.used_entries = plt_pkg::NUM_OUT_W'(peer_fill);
		return r;
	endfunction

	function automatic dir_row_t beat_row(plt_pkg::op_t func,
		logic [plt_pkg::ADDR_W-1:0] mac, logic [plt_pkg::GRP_W-1:0] grp, logic ok,
		logic [plt_pkg::TIME_W-1:0] now);
		dir_row_t row;
		row.kind = ROW_BEAT;
		row.beat.func = func;
		row.beat.mac = mac;
		row.beat.grp = grp;
		row.beat.frame_ok = ok;
		row.beat.now = now;
		row.typed = 1'b0;
		row.result = '0;
		row.leader = 1'b0;
		row.grp = '0;
		row.tmo = '0;
		return row;
	endfunction

	function automatic dir_row_t known(dir_row_t row, plt_pkg::status_t st, int slot, int cnt,
		logic [plt_pkg::MASK_W-1:0] mask, int used);
		row.typed = 1'b1;
		row.result = '0;
		row.result.status = st;
		row.result.entry_index = plt_pkg::SLOT_OUT_W'(slot);
		row.result.online_count = plt_pkg::NUM_OUT_W'(cnt);
		row.result.online_mask = mask;
		row.result.used_entries = plt_pkg::NUM_OUT_W'(used);
		return row;
	endfunction

	function automatic dir_row_t cfg_row(logic leader, logic [plt_pkg::GRP_W-1:0] grp,
		logic [plt_pkg::TMO_W-1:0] tmo);
		dir_row_t row;
		row = beat_row(plt_pkg::OP_LOOKUP, '0, '0, 1'b0, '0);
		row.kind = ROW_CFG;
		row.leader = leader;
		row.grp = grp;
		row.tmo = tmo;
		return row;
	endfunction

	// Valid stays high across back-to-back transactions; it only drops for a random gap or a drain.
	task automatic send_beat(beat_t b, bit typed, peer_result_t typed_result);
		peer_result_t predicted;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= b.func;
		in_ch.station_mac <= b.mac;
		in_ch.heartbeat_group <= b.grp;
		in_ch.frame_ok <= b.frame_ok;
		in_ch.now_ms <= b.now;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = track_beat(b);
		pending_q.push_back(typed ? typed_result : predicted);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic write_cfg(logic leader, logic [plt_pkg::GRP_W-1:0] grp,
		logic [plt_pkg::TMO_W-1:0] tmo);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		// Upper data bits are junk on purpose: only the register width is kept.
		cfg_we <= 1'b1;
		cfg_index <= plt_pkg::REG_LEADER;
		cfg_data <= {(plt_pkg::CFG_DATA_W - 1)'($urandom), leader};
		@(posedge clk);
		shadow_leader = leader;
		cfg_index <= plt_pkg::REG_GROUP;
		cfg_data <= {(plt_pkg::CFG_DATA_W - plt_pkg::GRP_W)'($urandom), grp};
		@(posedge clk);
		shadow_group = grp;
		cfg_index <= plt_pkg::REG_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		shadow_tmo = tmo;
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int count, logic leader, logic [plt_pkg::GRP_W-1:0] grp,
		logic [plt_pkg::TMO_W-1:0] tmo, int hold_at, int pause_at);
		beat_t b;
		logic [plt_pkg::TIME_W-1:0] clock_ms;
		int pick;
		int k;
		int n;
		write_cfg(leader, grp, tmo);
		clock_ms = $urandom;
		for (n = 0; n < count; n++) begin
			if (n == hold_at)
				long_hold_req <= 1'b1;
			if (n == pause_at)
				drain_results();
			pick = $urandom_range(0, 99);
			clock_ms = clock_ms + $urandom_range(0, int'(tmo) / 4 + 2);
			b.func = plt_pkg::OP_LOOKUP;
			b.frame_ok = 1'b1;
			b.grp = shadow_group;
			b.now = clock_ms;
			b.mac = (peer_fill > 0) ? peer_mac[$urandom_range(0, peer_fill - 1)]
				: {16'($urandom), 32'($urandom)};
			if (pick < 50) begin
				// Refresh of a known peer: the default above.
			end else if (pick < 75) begin
				b.func = plt_pkg::OP_SWEEP;
				b.frame_ok = 1'($urandom);
				b.grp = 8'($urandom);
				b.mac = {16'($urandom), 32'($urandom)};
				// Land some sweeps right on the timeout boundary of one entry.
				if (peer_fill > 0 && $urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, peer_fill - 1);
					clock_ms = peer_seen[k] + tmo + $urandom_range(0, 1);
					b.now = clock_ms;
				end
			end else if (pick < 83) begin
				b.mac = {16'($urandom), 32'($urandom)};
			end else if (pick < 91) begin
				b.frame_ok = 1'b0;
				b.grp = 8'($urandom);
			end else begin
				b.grp = shadow_group ^ 8'($urandom_range(1, 255));
			end
			send_beat(b, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		peer_result_t got;
		peer_result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.status = out_ch.status;
			got.entry_index = out_ch.entry_index;
			got.newly_offline = out_ch.newly_offline;
			got.online_count = out_ch.online_count;
			got.online_mask = out_ch.online_mask;
			got.used_entries = out_ch.used_entries;
			if (pending_q.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$display("[%0t] result with nothing pending: status %0d slot %0d",
						$time, got.status, got.entry_index);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (got.status !== want.status || got.entry_index !== want.entry_index ||
					got.newly_offline !== want.newly_offline ||
					got.online_count !== want.online_count ||
					got.online_mask !== want.online_mask ||
					got.used_entries !== want.used_entries) begin
					if (errors < REPORT_LIMIT) begin
						$display({"[%0t] expected status %0d slot %0d off %0d",
							" cnt %0d mask %h used %0d"},
							$time, want.status, want.entry_index, want.newly_offline,
							want.online_count, want.online_mask, want.used_entries);
						$display({"[%0t] actual   status %0d slot %0d off %0d",
							" cnt %0d mask %h used %0d"},
							$time, got.status, got.entry_index, got.newly_offline,
							got.online_count, got.online_mask, got.used_entries);
					end
					errors++;
				end
			end
		end
	end

	initial begin : result_sink
		int hold_left;
		bit long_hold_done;
		hold_left = 0;
		long_hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (long_hold_req && !long_hold_done) begin
				// One long back-pressure stretch so the input side has to stall.
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
				out_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 7);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		dir_row_t rows [$];
		int i;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= plt_pkg::REG_LEADER;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.func <= plt_pkg::OP_LOOKUP;
		in_ch.station_mac <= '0;
		in_ch.heartbeat_group <= '0;
		in_ch.frame_ok <= 1'b0;
		in_ch.now_ms <= '0;
		no_idle <= 1'b0;
		long_hold_req <= 1'b0;
		shadow_leader = 1'b0;
		shadow_group = '0;
		shadow_tmo = plt_pkg::TIMEOUT_RST;
		peer_fill = 0;
		for (i = 0; i < plt_pkg::MAX_PEERS; i++) begin
			peer_mac[i] = '0;
			peer_seen[i] = '0;
			peer_online[i] = 1'b0;
		end

		// Not leader wins over a bad frame and a wrong group; sweeps are refused too.
		rows.push_back(known(beat_row(plt_pkg::OP_LOOKUP, 48'h1234_5678_9ABC, 8'h3C, 1'b0,
			32'h0), plt_pkg::ST_NOT_LEADER, 0, 0, 8'h00, 0));
		rows.push_back(known(beat_row(plt_pkg::OP_SWEEP, '0, '0, 1'b1, 32'hFFFF_FFFF),
			plt_pkg::ST_NOT_LEADER, 0, 0, 8'h00, 0));
		rows.push_back(cfg_row(1'b1, 8'hA5, 16'd100));
		rows.push_back(known(beat_row(plt_pkg::OP_LOOKUP, '0, 8'h3C, 1'b0, 32'h0),
			plt_pkg::ST_BAD_FRAME, 0, 0, 8'h00, 0));
		rows.push_back(known(beat_row(plt_pkg::OP_LOOKUP, '0, 8'h3C, 1'b1, 32'h0),
			plt_pkg::ST_WRONG_GROUP, 0, 0, 8'h00, 0));
		rows.push_back(known(beat_row(plt_pkg::OP_LOOKUP, '0, 8'hA5, 1'b1, 32'h0),
			plt_pkg::ST_ADDED, 0, 1, 8'h01, 1));
		rows.push_back(known(beat_row(plt_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'hA5, 1'b1,
			32'hFFFF_FFFF), plt_pkg::ST_ADDED, 1, 2, 8'h03, 2));
		rows.push_back(known(beat_row(plt_pkg::OP_LOOKUP, '0, 8'hA5, 1'b1, 32'd1000),
			plt_pkg::ST_REFRESHED, 0, 2, 8'h03, 2));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, 48'h0000_0000_0001, 8'hA5, 1'b1, 32'd1000));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, 48'h8000_0000_0000, 8'hA5, 1'b1, 32'd1000));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, 8'hA5, 1'b1, 32'd1000));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, 48'h5555_5555_5555, 8'hA5, 1'b1, 32'd1000));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, 48'h0123_4567_89AB, 8'hA5, 1'b1, 32'd1000));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, 48'hFEDC_BA98_7654, 8'hA5, 1'b1, 32'd1000));
		rows.push_back(known(beat_row(plt_pkg::OP_LOOKUP, 48'h7FFF_FFFF_FFFF, 8'hA5, 1'b1,
			32'd1000), plt_pkg::ST_FULL, 0, 8, 8'hFF, 8));
		// The slot last seen at the top of the time range has a wrapped age of 1101.
		rows.push_back(beat_row(plt_pkg::OP_SWEEP, 48'h0, 8'h00, 1'b0, 32'd1100));
		rows.push_back(beat_row(plt_pkg::OP_SWEEP, 48'h0, 8'hA5, 1'b1, 32'd1101));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'hA5, 1'b1, 32'd5));
		rows.push_back(cfg_row(1'b1, 8'hA5, 16'd0));
		rows.push_back(beat_row(plt_pkg::OP_SWEEP, '0, 8'hA5, 1'b1, 32'd5));
		rows.push_back(beat_row(plt_pkg::OP_SWEEP, '0, 8'hA5, 1'b1, 32'd6));
		rows.push_back(cfg_row(1'b1, 8'hA5, 16'hFFFF));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, '0, 8'hA5, 1'b1, 32'hFFFF_FFF0));
		rows.push_back(beat_row(plt_pkg::OP_SWEEP, '0, 8'hA5, 1'b1, 32'h0000_FFEF));
		rows.push_back(beat_row(plt_pkg::OP_SWEEP, '0, 8'hA5, 1'b1, 32'h0000_FFF0));
		rows.push_back(cfg_row(1'b0, 8'h00, 16'hFFFF));
		rows.push_back(beat_row(plt_pkg::OP_SWEEP, '0, 8'h00, 1'b1, 32'd0));
		rows.push_back(beat_row(plt_pkg::OP_LOOKUP, '0, 8'h00, 1'b1, 32'd0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].kind == ROW_CFG)
				write_cfg(rows[r].leader, rows[r].grp, rows[r].tmo);
			else
				send_beat(rows[r].beat, rows[r].typed, rows[r].result);
		end

		run_phase(130, 1'b1, 8'hFF, 16'd40, NO_EVENT, NO_EVENT);
		run_phase(130, 1'b1, 8'($urandom), 16'($urandom_range(1, 400)), 10, NO_EVENT);
		run_phase(30, 1'b0, 8'h00, 16'd3000, NO_EVENT, NO_EVENT);
		run_phase(120, 1'b1, 8'h00, 16'd0, NO_EVENT, 60);
		no_idle <= 1'b1;
		run_phase(120, 1'b1, 8'($urandom), 16'hFFFF, NO_EVENT, NO_EVENT);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * 200000);
		$display("Mismatches found");
		$finish;
	end

endmodule
